// File: rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue unit.
// No dependencies; every other file in rtl imports this package.
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;

  // Request kinds as they arrive on the input channel.
  typedef enum logic [REQ_W-1:0] {
    RQ_PUSH_F = 3'd0,
    RQ_PUSH_B = 3'd1,
    RQ_POP_F  = 3'd2,
    RQ_POP_B  = 3'd3,
    RQ_DUMP_F = 3'd4,
    RQ_DUMP_B = 3'd5
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell of the row does in a cycle.
  typedef enum logic [2:0] {
    CO_HOLD   = 3'd0,
    CO_PUSH_F = 3'd1,
    CO_PUSH_B = 3'd2,
    CO_POP_F  = 3'd3,
    CO_ROT_F  = 3'd4,
    CO_ROT_B  = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_t;

endpackage

// File: rtl/dq_in_if.sv
// Request channel of the double-ended queue unit: valid/ready plus payload.
// Depends on dq_pkg.
interface dq_in_if;
  import dq_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  data_t              value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// File: rtl/dq_out_if.sv
// Result channel of the double-ended queue unit: valid/ready plus payload.
// Depends on dq_pkg.
interface dq_out_if;
  import dq_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  data_t              data;
  logic               last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// File: rtl/dq_cell.sv
// One storage cell of the deque row: holds one element and takes a value from
// a neighbour, the insert bus or the front cell each cycle. Depends on dq_pkg.
module dq_cell (
  input  logic                      clk,
  input  dq_pkg::cell_ctl_t         ctl,
  input  logic [dq_pkg::IDX_W-1:0]  cell_idx,
  input  dq_pkg::data_t             ins_d,
  input  dq_pkg::data_t             left_d,
  input  dq_pkg::data_t             right_d,
  input  dq_pkg::data_t             head_d,
  output dq_pkg::data_t             q
);
  import dq_pkg::*;

  data_t            q_r;
  data_t            q_nxt;
  logic [CNT_W-1:0] pos;
  logic             at_end;
  logic             at_back;
  logic             occupied;

  assign pos      = CNT_W'(cell_idx);
  assign at_end   = (pos == ctl.cnt);
  assign at_back  = (CNT_W'(pos + 1'b1) == ctl.cnt);
  assign occupied = (pos < ctl.cnt);

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      CO_HOLD:   q_nxt = q_r;
      CO_PUSH_F: q_nxt = left_d;
      CO_PUSH_B: if (at_end) q_nxt = ins_d;
      CO_POP_F:  q_nxt = right_d;
      // The back cell takes the front cell's old value, so the front element wraps round.
      CO_ROT_F:  if (occupied) q_nxt = at_back ? head_d : right_d;
      CO_ROT_B:  if (occupied) q_nxt = left_d;
      default:   q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, output register and the
// row of dq_cell storage cells. Depends on dq_pkg, dq_in_if, dq_out_if, dq_cell.
//
// A bounded deque of DEPTH signed 32-bit elements, held as a row of cells with
// the front element always in cell 0 and the back element in cell count-1.
// Push front and pop front shift the whole row by one cell; push back writes
// the cell just past the back; pop back only reads. Every push or pop gives a
// single result item, so such requests stream at one item per cycle as long as
// the result side keeps taking items. A dump of N elements rotates the
// occupied part of the row by one cell per cycle while the output register
// is free, and emits the element leaving the front (or the back) each time,
// one result item per rotation; no new request is taken until the item marked
// last has been loaded into the output register. After
// N rotations the row is back in its original order. An empty dump, a pop on
// an empty deque and a push on a full one each give one item with the
// matching status. Request codes 6 and 7 are taken and dropped without a
// result. All results pass through one output register, which is refilled in
// the same cycle that its item is taken.
module double_ended_queue_unit (
  input  logic   clk,
  input  logic   rst_n,
  dq_in_if.sink    in_req,
  dq_out_if.source out_res
);
  import dq_pkg::*;

  // Queue bookkeeping.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             dir_r, dir_nxt;       // 1 while dumping back to front
  fsm_t             state_r, state_nxt;

  // Output register.
  logic             out_valid_r;
  status_t          out_status_r;
  data_t            out_data_r;
  logic             out_last_r;

  // Result being produced this cycle.
  logic             emit;
  status_t          e_status;
  data_t            e_data;
  logic             e_last;

  logic             out_free;
  logic             in_fire;
  logic             dump_req;
  req_kind_t        kind;
  cell_op_t         ctl_op;
  cell_ctl_t        ctl;

  data_t            cell_q [DEPTH];
  data_t            front_d;
  data_t            back_d;
  data_t            feed_d;
  logic [CNT_W-1:0] cnt_m1;

  assign out_free = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == FSM_IDLE) && out_free;
  assign in_fire  = in_req.valid && in_req.ready;
  assign kind     = req_kind_t'(in_req.req_type);
  assign dump_req = (kind == RQ_DUMP_F) || (kind == RQ_DUMP_B);

  assign cnt_m1  = CNT_W'(cnt_r - 1'b1);
  assign front_d = cell_q[0];
  assign back_d  = cell_q[cnt_m1[IDX_W-1:0]];

  // Cell 0 takes the new element on a push front, and the old back element
  // when the row rotates towards the back.
  assign feed_d = (ctl_op == CO_ROT_B) ? back_d : in_req.value;

  assign ctl = '{op: ctl_op, cnt: cnt_r};

  // The storage row. Each cell sees its neighbours and the front cell; cell 0 takes feed_d on its left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_d;
    data_t right_d;

    if (i == 0) begin : g_first
      assign left_d = feed_d;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_d = front_d;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    dq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (IDX_W'(i)),
      .ins_d    (in_req.value),
      .left_d   (left_d),
      .right_d  (right_d),
      .head_d   (front_d),
      .q        (cell_q[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_fire && dump_req && (cnt_r != '0)) state_nxt = FSM_DUMP;
      FSM_DUMP: if (out_free && (rem_r == CNT_W'(1))) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Outputs of the control: cell operation, result item and counters.
  always_comb begin
    ctl_op   = CO_HOLD;
    emit     = 1'b0;
    e_status = ST_OK;
    e_data   = '0;
    e_last   = 1'b1;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dir_nxt  = dir_r;

    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          unique case (kind)
            RQ_PUSH_F, RQ_PUSH_B: begin
              emit = 1'b1;
              if (cnt_r == CNT_W'(DEPTH)) begin
                e_status = ST_FULL;
              end else begin
                ctl_op  = (kind == RQ_PUSH_F) ? CO_PUSH_F : CO_PUSH_B;
                cnt_nxt = CNT_W'(cnt_r + 1'b1);
              end
            end
            RQ_POP_F, RQ_POP_B: begin
              emit = 1'b1;
              if (cnt_r == '0) begin
                e_status = ST_EMPTY;
              end else begin
                if (kind == RQ_POP_F) begin
                  ctl_op = CO_POP_F;
                  e_data = front_d;
                end else begin
                  e_data = back_d;
                end
                cnt_nxt = cnt_m1;
              end
            end
            RQ_DUMP_F, RQ_DUMP_B: begin
              if (cnt_r == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                rem_nxt = cnt_r;
                dir_nxt = (kind == RQ_DUMP_B);
              end
            end
            default: ;
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          emit    = 1'b1;
          e_data  = dir_r ? back_d : front_d;
          e_last  = (rem_r == CNT_W'(1));
          ctl_op  = dir_r ? CO_ROT_B : CO_ROT_F;
          rem_nxt = CNT_W'(rem_r - 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      dir_r   <= dir_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_status;
      out_data_r   <= e_data;
      out_last_r   <= e_last;
    end
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.status = out_status_r;
  assign out_res.data   = out_data_r;
  assign out_res.last   = out_last_r;

endmodule

// File: rtl/dq_checker.sv
// Port-level checks for the double-ended queue unit, bound to its top level.
// Depends on dq_pkg and double_ended_queue_unit.
module dq_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [dq_pkg::REQ_W-1:0]    in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dq_pkg::STAT_W-1:0]   out_status,
  input dq_pkg::data_t               out_data,
  input logic                        out_last
);
  import dq_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_data) && $stable(out_last))
    else $error("result item changed while stalled");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request accepted in the middle of a dump");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_data == '0) && out_last)
    else $error("error result with data or without last");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ((in_req_type == RQ_POP_F) || (in_req_type == RQ_POP_B))
      |=> out_valid && out_last && (out_status != ST_FULL))
    else $error("pop did not give a single result in the next cycle");

endmodule

bind double_ended_queue_unit dq_port_checker u_dq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .in_req_type (in_req.req_type),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_status  (out_res.status),
  .out_data    (out_res.data),
  .out_last    (out_res.last)
);

// File: tb/dq_checker.sv
// Checker for the double-ended queue unit: keeps its own copy of the deque,
// predicts the result items of every accepted request and compares them in order.
// Depends on dq_pkg, dq_in_if and dq_out_if.
module dq_checker (
  input  logic clk,
  input  logic rst_n,
  dq_in_if     req_mon,
  dq_out_if    res_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  typedef struct {
    status_t status;
    data_t   data;
    logic    last;
  } result_t;

  // Shadow deque: ring of slots, index of the front element and fill level.
  data_t   ring [DEPTH];
  int      head_idx;
  int      fill;
  result_t due_results [$];
  int      mismatches = 0;
  int      waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  function automatic void note_result(status_t st, data_t d, logic lst);
    result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    due_results.push_back(r);
  endfunction

  function automatic void apply_request(logic [REQ_W-1:0] kind, data_t value);
    int pos;
    case (kind)
      RQ_PUSH_F, RQ_PUSH_B: begin
        if (fill == DEPTH) begin
          note_result(ST_FULL, '0, 1'b1);
        end else begin
          if (kind == RQ_PUSH_F) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            ring[head_idx] = value;
          end else begin
            ring[(head_idx + fill) % DEPTH] = value;
          end
          fill++;
          note_result(ST_OK, '0, 1'b1);
        end
      end
      RQ_POP_F, RQ_POP_B: begin
        if (fill == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (kind == RQ_POP_F) begin
            pos = head_idx;
            head_idx = (head_idx + 1) % DEPTH;
          end else begin
            pos = (head_idx + fill - 1) % DEPTH;
          end
          fill--;
          note_result(ST_OK, ring[pos], 1'b1);
        end
      end
      RQ_DUMP_F, RQ_DUMP_B: begin
        if (fill == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) begin
            pos = (kind == RQ_DUMP_F) ? i : fill - 1 - i;
            note_result(ST_OK, ring[(head_idx + pos) % DEPTH], i == fill - 1);
          end
        end
      end
      default: ;  // spare codes are swallowed without a result
    endcase
  endfunction

  // Results are compared before the request of the same edge is applied, as a
  // request can never produce a result in the cycle it is taken.
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      due_results.delete();
      head_idx = 0;
      fill     = 0;
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $error("unexpected result: status %0d, data %0d, last %0d",
                 res_mon.status, res_mon.data, res_mon.last);
        end else begin
          want = due_results.pop_front();
          if (res_mon.status !== want.status) begin
            mismatches++;
            $error("status mismatch: expected %0d, actual %0d", want.status, res_mon.status);
          end
          if (res_mon.data !== want.data) begin
            mismatches++;
            $error("data mismatch: expected %0d, actual %0d", want.data, res_mon.data);
          end
          if (res_mon.last !== want.last) begin
            mismatches++;
            $error("last mismatch: expected %0d, actual %0d", want.last, res_mon.last);
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        apply_request(req_mon.req_type, req_mon.value);
      end
    end
    waiting = due_results.size();
  end

endmodule

// File: tb/double_ended_queue_unit_tb.sv
// Top of the double-ended queue unit testbench: clock, reset, request and
// result traffic, and the verdict. Depends on dq_pkg, both channel interfaces,
// double_ended_queue_unit and dq_checker.
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  localparam int PERIOD        = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int TOTAL_ITEMS   = 170;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_NS   = 8_000_000;

  // Request codes that the unit takes and drops without a result.
  localparam logic [REQ_W-1:0] RQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] RQ_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  req_ch ();
  dq_out_if res_ch ();

  int fail_count;
  int outstanding;

  // The stimulus asks for a long hold on the result side by raising
  // hold_asked; the result side serves each request once.
  int hold_asked  = 0;
  int hold_served = 0;

  // Requests taken by the unit, leaving out the spare codes it ignores.
  int taken_items = 0;

  always #(PERIOD / 2) clk = ~clk;

  double_ended_queue_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  dq_checker deque_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .res_mon     (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Values are mostly uniform over the whole 32-bit range, with the extremes
  // and the values around zero mixed in now and then.
  function automatic data_t pick_value();
    case ($urandom_range(0, 11))
      0:       return data_t'(32'h8000_0000);
      1:       return data_t'(32'h7fff_ffff);
      2:       return '0;
      3:       return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Mixed traffic leans towards pushes so that the deque holds something
  // worth dumping, and now and then offers a spare code.
  function automatic logic [REQ_W-1:0] pick_mixed_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 22) return RQ_PUSH_F;
    if (roll < 45) return RQ_PUSH_B;
    if (roll < 60) return RQ_POP_F;
    if (roll < 75) return RQ_POP_B;
    if (roll < 85) return RQ_DUMP_F;
    if (roll < 95) return RQ_DUMP_B;
    return $urandom_range(0, 1) ? RQ_SPARE_7 : RQ_SPARE_6;
  endfunction

  // Offers one request and returns at the edge where it is taken. The valid
  // line is left high, so a following request goes out back to back.
  task automatic send_req(input logic [REQ_W-1:0] kind, input data_t value);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= value;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    if (kind != RQ_SPARE_6 && kind != RQ_SPARE_7) taken_items++;
  endtask

  // Random idle time on the request side, drawn now and then, with an
  // occasional long pause. A steady stretch never idles.
  task automatic maybe_gap(input bit steady);
    int cycles;
    if (!steady && $urandom_range(0, 99) < 30) begin
      cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops offering requests until every predicted result has come back. The
  // first edge lets the checker account for the request taken just before.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int episode;
    int pick;
    int n;
    bit steady;
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= RQ_PUSH_F;
    req_ch.value    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Pops and dumps on the empty deque must all report
    // empty; then four values (both extremes, minus one and zero) go in at both
    // ends, the spare codes are offered and must leave no trace, and both dumps
    // and both pops check the ordering.
    send_req(RQ_POP_F, pick_value());
    send_req(RQ_POP_B, pick_value());
    maybe_gap(1'b0);
    send_req(RQ_DUMP_F, pick_value());
    send_req(RQ_DUMP_B, pick_value());
    send_req(RQ_PUSH_F, data_t'(32'h8000_0000));
    send_req(RQ_PUSH_B, data_t'(32'h7fff_ffff));
    maybe_gap(1'b0);
    send_req(RQ_PUSH_F, '1);
    send_req(RQ_PUSH_B, '0);
    send_req(RQ_SPARE_6, data_t'($urandom));
    send_req(RQ_SPARE_7, data_t'($urandom));
    send_req(RQ_DUMP_F, pick_value());
    send_req(RQ_DUMP_B, pick_value());
    maybe_gap(1'b0);
    send_req(RQ_POP_F, pick_value());
    send_req(RQ_POP_B, pick_value());

    // The sender pauses until everything is back before the random part.
    wait_drained();

    // Random part, in episodes. The first one always fills the deque past
    // its bound while the result side holds off for a long stretch, so the
    // output register backs up and the unit has to stall its request side.
    episode = 0;
    while (taken_items < TOTAL_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      pick   = (episode == 0) ? 0 : $urandom_range(0, 19);
      if (pick < 5) begin
        // Fill: enough pushes to reach full from any level, plus refused ones.
        if (episode == 0 || $urandom_range(0, 3) == 0) begin
          hold_asked++;
          steady = 1'b1;
          // The pushes start only once the result side has begun its hold.
          wait (hold_served == hold_asked);
        end
        n = $urandom_range(DEPTH + 1, DEPTH + 4);
        repeat (n) begin
          send_req($urandom_range(0, 1) ? RQ_PUSH_B : RQ_PUSH_F, pick_value());
          maybe_gap(steady);
        end
      end else if (pick < 9) begin
        // Drain: enough pops to empty the deque, then a dump of the empty one.
        n = $urandom_range(DEPTH + 1, DEPTH + 3);
        repeat (n) begin
          send_req($urandom_range(0, 1) ? RQ_POP_B : RQ_POP_F, pick_value());
          maybe_gap(steady);
        end
        send_req($urandom_range(0, 1) ? RQ_DUMP_B : RQ_DUMP_F, pick_value());
        maybe_gap(steady);
      end else if (pick < 19) begin
        n = $urandom_range(6, 16);
        repeat (n) begin
          send_req(pick_mixed_kind(), pick_value());
          maybe_gap(steady);
        end
      end else begin
        wait_drained();
      end
      episode++;
    end

    // Let every predicted result arrive, then give the unit time to show any
    // stray item it might still send.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: short random holds, the odd long one, stretches where every
  // item is taken at once, and the long hold-off whenever the stimulus asks.
  initial begin : result_side
    int cycles;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_served != hold_asked) begin
        hold_served++;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
            res_ch.ready <= 1'b0;
            repeat (cycles) @(posedge clk);
          end
          4: begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(30, 60)) @(posedge clk);
          end
          default: begin
            res_ch.ready <= 1'b1;
            @(posedge clk);
          end
        endcase
      end
    end
  end

  // Hard limit on the run, well beyond the slowest correct one.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
